// ===== hw/rtl/tape_pulse_train_encoder_macros.svh =====
// Assertion macros for the tape pulse train encoder RTL (used by tpte_back)
`ifndef TAPE_PULSE_TRAIN_ENCODER_MACROS_SVH
`define TAPE_PULSE_TRAIN_ENCODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TPTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tpte_pkg.sv =====
// Types and constants of the tape pulse train encoder
`default_nettype none
package tpte_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 3'd5;

    localparam logic [5:0]         RST_HALF  = 6'd4;
    localparam logic [7:0]         RST_PAUSE = 8'd32;
    localparam logic [3:0]         RST_ZERO  = 4'd4;
    localparam logic [3:0]         RST_ONE   = 4'd9;
    localparam logic signed [15:0] RST_HIGH  = 16'sh7FFF;
    localparam logic signed [15:0] RST_LOW   = 16'sh8000;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic {
        OP_LOAD,
        OP_TICK
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_PAUSE
    } t_phase;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [5:0]         half_pulse_samples;
        logic [7:0]         pause_samples;
        logic [3:0]         zero_pulses;
        logic [3:0]         one_pulses;
        logic signed [15:0] high_level;
        logic signed [15:0] low_level;
    } t_cfg;

    typedef struct packed {
        logic               kind;
        logic               accepted;
        logic signed [15:0] sample;
        logic               active;
        logic               byte_done;
    } t_result;

endpackage
`default_nettype wire

// ===== hw/rtl/tpte_in_if.sv =====
// Input channel: load or tick items
`default_nettype none
interface tpte_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tpte_out_if.sv =====
// Output channel: load acknowledges and waveform samples
`default_nettype none
interface tpte_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic               accepted;
    logic signed [15:0] sample;
    logic               active;
    logic               byte_done;

    modport source (output valid, output kind, output accepted, output sample,
                    output active, output byte_done, input ready);
    modport sink   (input valid, input kind, input accepted, input sample,
                    input active, input byte_done, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tpte_front.sv =====
// Front end: accepts input transfers, classifies them and queues them
`default_nettype none
module tpte_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tpte_in_if.sink            i_in,
    output tpte_pkg::t_item    o_item,
    output logic               o_item_valid,
    input  wire logic          i_pop
);

    tpte_pkg::t_item                r_mem [tpte_pkg::QDEPTH];
    logic [tpte_pkg::QAW-1:0]       r_wr_ptr;
    logic [tpte_pkg::QAW-1:0]       r_rd_ptr;
    logic [tpte_pkg::QCW-1:0]       r_count;
    logic [tpte_pkg::QAW-1:0]       n_wr_ptr;
    logic [tpte_pkg::QAW-1:0]       n_rd_ptr;
    logic [tpte_pkg::QCW-1:0]       n_count;
    logic                           push;
    logic                           pop;
    tpte_pkg::t_item                cls_item;

    assign i_in.ready   = (r_count != tpte_pkg::QCW'(tpte_pkg::QDEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        cls_item.op        = (i_in.func == tpte_pkg::FUNC_TICK) ? tpte_pkg::OP_TICK
                                                                : tpte_pkg::OP_LOAD;
        cls_item.data_byte = i_in.data_byte;
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tpte_back.sv =====
// Back end: bit/pulse/pause sequencer and registered result stage
`default_nettype none
`include "tape_pulse_train_encoder_macros.svh"
module tpte_back #(
    parameter int SAMPLE_BITS = tpte_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tpte_pkg::t_item i_item,
    input  wire logic            i_item_valid,
    output logic                 o_pop,
    input  wire tpte_pkg::t_cfg  i_cfg,
    tpte_out_if.source           o_out
);

    localparam int LVL_MAX_I = (SAMPLE_BITS >= 16) ? 32767 : (1 << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [15:0] LVL_MAX = 16'(LVL_MAX_I);
    localparam logic signed [15:0] LVL_MIN = 16'(-LVL_MAX_I - 1);

    tpte_pkg::t_phase   r_phase, n_phase;
    logic [7:0]         r_shift, n_shift;
    logic [3:0]         r_bits, n_bits;
    logic [3:0]         r_pulses, n_pulses;
    logic [7:0]         r_left, n_left;
    logic               r_out_valid, n_out_valid;
    tpte_pkg::t_result  r_res, n_res;

    logic [7:0]         half_cnt;
    logic [7:0]         pause_cnt;
    logic [3:0]         one_cnt;
    logic [3:0]         zero_cnt;
    logic signed [15:0] high_sat;
    logic signed [15:0] low_sat;

    assign o_pop = i_item_valid && (!r_out_valid || o_out.ready);

    // zero count registers act as one; levels clamp to the sample range
    always_comb begin
        half_cnt  = (i_cfg.half_pulse_samples == '0) ? 8'd1 : {2'b00, i_cfg.half_pulse_samples};
        pause_cnt = (i_cfg.pause_samples == '0) ? 8'd1 : i_cfg.pause_samples;
        one_cnt   = (i_cfg.one_pulses == '0) ? 4'd1 : i_cfg.one_pulses;
        zero_cnt  = (i_cfg.zero_pulses == '0) ? 4'd1 : i_cfg.zero_pulses;
        high_sat  = (i_cfg.high_level > LVL_MAX) ? LVL_MAX :
                    (i_cfg.high_level < LVL_MIN) ? LVL_MIN : i_cfg.high_level;
        low_sat   = (i_cfg.low_level > LVL_MAX) ? LVL_MAX :
                    (i_cfg.low_level < LVL_MIN) ? LVL_MIN : i_cfg.low_level;
    end

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_pulses = r_pulses;
        n_left   = r_left;
        n_res    = r_res;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            if (i_item.op == tpte_pkg::OP_LOAD) begin
                n_res.kind = tpte_pkg::KIND_ACK;
                if (r_phase == tpte_pkg::PH_IDLE) begin
                    n_res.accepted = 1'b1;
                    n_shift  = i_item.data_byte;
                    n_bits   = tpte_pkg::BITS_PER_BYTE;
                    n_pulses = i_item.data_byte[7] ? one_cnt : zero_cnt;
                    n_phase  = tpte_pkg::PH_HIGH;
                    n_left   = half_cnt;
                end
            end else begin
                n_res.kind = tpte_pkg::KIND_SAMPLE;
                if (r_phase == tpte_pkg::PH_IDLE) begin
                    n_res.sample = low_sat;
                end else begin
                    n_res.sample = (r_phase == tpte_pkg::PH_HIGH) ? high_sat : low_sat;
                    n_res.active = 1'b1;
                    if (r_left > 8'd1) begin
                        n_left = r_left - 1'b1;
                    end else begin
                        case (r_phase)
                            tpte_pkg::PH_HIGH: begin
                                n_phase = tpte_pkg::PH_LOW;
                                n_left  = half_cnt;
                            end
                            tpte_pkg::PH_LOW: begin
                                n_pulses = r_pulses - 1'b1;
                                if (r_pulses != 4'd1) begin
                                    n_phase = tpte_pkg::PH_HIGH;
                                    n_left  = half_cnt;
                                end else begin
                                    n_phase = tpte_pkg::PH_PAUSE;
                                    n_left  = pause_cnt;
                                end
                            end
                            tpte_pkg::PH_PAUSE: begin
                                n_bits  = r_bits - 1'b1;
                                n_shift = {r_shift[6:0], 1'b0};
                                if (r_bits != 4'd1) begin
                                    n_pulses = r_shift[6] ? one_cnt : zero_cnt;
                                    n_phase  = tpte_pkg::PH_HIGH;
                                    n_left   = half_cnt;
                                end else begin
                                    n_phase  = tpte_pkg::PH_IDLE;
                                    n_left   = '0;
                                    n_pulses = '0;
                                    n_res.byte_done = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tpte_pkg::PH_IDLE;
            r_shift     <= '0;
            r_bits      <= '0;
            r_pulses    <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits      <= n_bits;
            r_pulses    <= n_pulses;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_res.kind;
    assign o_out.accepted  = r_res.accepted;
    assign o_out.sample    = r_res.sample;
    assign o_out.active    = r_res.active;
    assign o_out.byte_done = r_res.byte_done;

    `TPTE_ASSERT_IMP(a_idle_clear, i_clk, i_rst_n, r_phase == tpte_pkg::PH_IDLE, r_bits == '0 && r_pulses == '0 && r_left == '0, "idle with live counters")
    `TPTE_ASSERT_IMP(a_busy_counts, i_clk, i_rst_n, r_phase != tpte_pkg::PH_IDLE, r_bits != '0 && r_left != '0, "busy with empty counters")
    `TPTE_ASSERT_NXT(a_busy_load_kept, i_clk, i_rst_n, o_pop && i_item.op == tpte_pkg::OP_LOAD && r_phase != tpte_pkg::PH_IDLE, $stable(r_phase) && $stable(r_shift) && $stable(r_bits) && $stable(r_left), "refused load changed state")
    `TPTE_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_pop && n_res.byte_done, r_phase == tpte_pkg::PH_IDLE && r_res.active, "byte end not idle")

endmodule
`default_nettype wire

// ===== hw/rtl/tape_pulse_train_encoder.sv =====
// Tape pulse train encoder top level: config registers, front end, back end
//
// Usage:
//   i_in carries items: func = load (data_byte to send) or tick (one sample).
//   o_out returns exactly one result per input transfer, in order: a load
//   acknowledge (accepted = 0 if a byte is still being sent) or a sample with
//   active and byte_done flags. Bits go out MSB first; each bit is a train of
//   high/low pulses followed by a low pause.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
//   must write them only while the block is idle, which the block does not
//   enforce. Index 0..5 = half pulse, pause, zero pulses, one pulses, high
//   level, low level. Other indexes are ignored.
//   A result passes through the queue and then the result register.
//   Throughput: one item per cycle while the result register is empty or read.
//   A 4-entry queue sits between front and back; when o_out stalls the
//   result register holds, the queue fills and then i_in.ready drops.
//   Synchronous reset returns the registers to their defaults, clears the
//   queue and the result valid flag and leaves the sequencer idle.
`default_nettype none
module tape_pulse_train_encoder #(
    parameter int SAMPLE_BITS = tpte_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tpte_in_if.sink                              i_in,
    tpte_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tpte_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tpte_pkg::t_cfg  r_cfg, n_cfg;
    tpte_pkg::t_item item;
    logic            item_valid;
    logic            pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tpte_pkg::CFG_HALF:  n_cfg.half_pulse_samples = i_cfg_data[5:0];
                tpte_pkg::CFG_PAUSE: n_cfg.pause_samples      = i_cfg_data[7:0];
                tpte_pkg::CFG_ZERO:  n_cfg.zero_pulses        = i_cfg_data[3:0];
                tpte_pkg::CFG_ONE:   n_cfg.one_pulses         = i_cfg_data[3:0];
                tpte_pkg::CFG_HIGH:  n_cfg.high_level         = i_cfg_data;
                tpte_pkg::CFG_LOW:   n_cfg.low_level          = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_pulse_samples <= tpte_pkg::RST_HALF;
            r_cfg.pause_samples      <= tpte_pkg::RST_PAUSE;
            r_cfg.zero_pulses        <= tpte_pkg::RST_ZERO;
            r_cfg.one_pulses         <= tpte_pkg::RST_ONE;
            r_cfg.high_level         <= tpte_pkg::RST_HIGH;
            r_cfg.low_level          <= tpte_pkg::RST_LOW;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tpte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    tpte_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .i_cfg        (r_cfg),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

// ===== bench/tpte_waveform_check.sv =====
// Checker for the tape pulse train encoder: tracks config writes, predicts and compares results
module tpte_waveform_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tpte_in_if                              in_mon,
    tpte_out_if                             out_mon,
    input  logic                            i_cfg_we,
    input  logic [tpte_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpte_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import tpte_pkg::*;

    t_cfg       cfg;
    t_phase     seq_phase;
    logic [7:0] tx_byte;
    logic [3:0] bits_left;
    logic [3:0] pulses_left;
    logic [7:0] samples_left;
    t_result    pending_waveform[$];
    int         mismatches = 0;

    function automatic logic [7:0] count_or_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic void open_bit();
        logic [3:0] n;
        n = tx_byte[7] ? cfg.one_pulses : cfg.zero_pulses;
        pulses_left  = (n == 4'd0) ? 4'd1 : n;
        seq_phase    = PH_HIGH;
        samples_left = count_or_one({2'b00, cfg.half_pulse_samples});
    endfunction

    function automatic t_result encoder_step(input logic func, input logic [7:0] data);
        t_result r;
        r = '0;
        if (func == FUNC_LOAD) begin
            r.kind = KIND_ACK;
            if (seq_phase == PH_IDLE) begin
                tx_byte    = data;
                bits_left  = BITS_PER_BYTE;
                open_bit();
                r.accepted = 1'b1;
            end
        end else begin
            r.kind = KIND_SAMPLE;
            if (seq_phase == PH_IDLE) begin
                r.sample = cfg.low_level;
            end else begin
                r.sample = (seq_phase == PH_HIGH) ? cfg.high_level : cfg.low_level;
                r.active = 1'b1;
                if (samples_left > 8'd1) begin
                    samples_left = samples_left - 8'd1;
                end else if (seq_phase == PH_HIGH) begin
                    seq_phase    = PH_LOW;
                    samples_left = count_or_one({2'b00, cfg.half_pulse_samples});
                end else if (seq_phase == PH_LOW) begin
                    pulses_left = pulses_left - 4'd1;
                    if (pulses_left != 4'd0) begin
                        seq_phase    = PH_HIGH;
                        samples_left = count_or_one({2'b00, cfg.half_pulse_samples});
                    end else begin
                        seq_phase    = PH_PAUSE;
                        samples_left = count_or_one(cfg.pause_samples);
                    end
                end else begin
                    bits_left = bits_left - 4'd1;
                    tx_byte   = tx_byte << 1;
                    if (bits_left != 4'd0) begin
                        open_bit();
                    end else begin
                        seq_phase    = PH_IDLE;
                        samples_left = 8'd0;
                        pulses_left  = 4'd0;
                        r.byte_done  = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.half_pulse_samples = RST_HALF;
            cfg.pause_samples      = RST_PAUSE;
            cfg.zero_pulses        = RST_ZERO;
            cfg.one_pulses         = RST_ONE;
            cfg.high_level         = RST_HIGH;
            cfg.low_level          = RST_LOW;
            seq_phase              = PH_IDLE;
            tx_byte                = '0;
            bits_left              = '0;
            pulses_left            = '0;
            samples_left           = '0;
            pending_waveform.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                got.kind      = out_mon.kind;
                got.accepted  = out_mon.accepted;
                got.sample    = out_mon.sample;
                got.active    = out_mon.active;
                got.byte_done = out_mon.byte_done;
                if (pending_waveform.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing outstanding: kind %0b acc %0b sample %0d active %0b done %0b",
                                 $realtime, got.kind, got.accepted, got.sample, got.active,
                                 got.byte_done);
                end else begin
                    want = pending_waveform.pop_front();
                    if (got.kind !== want.kind || got.accepted !== want.accepted ||
                        got.sample !== want.sample || got.active !== want.active ||
                        got.byte_done !== want.byte_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch: exp kind %0b acc %0b sample %0d active %0b done %0b, got kind %0b acc %0b sample %0d active %0b done %0b",
                                     $realtime, want.kind, want.accepted, want.sample,
                                     want.active, want.byte_done, got.kind, got.accepted,
                                     got.sample, got.active, got.byte_done);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HALF:  cfg.half_pulse_samples = i_cfg_data[5:0];
                    CFG_PAUSE: cfg.pause_samples      = i_cfg_data[7:0];
                    CFG_ZERO:  cfg.zero_pulses        = i_cfg_data[3:0];
                    CFG_ONE:   cfg.one_pulses         = i_cfg_data[3:0];
                    CFG_HIGH:  cfg.high_level         = i_cfg_data;
                    CFG_LOW:   cfg.low_level          = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                pending_waveform.push_back(encoder_step(in_mon.func, in_mon.data_byte));
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_waveform.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the tape pulse train encoder: clock, reset, stimulus and verdict
module tb_top;
    import tpte_pkg::*;

    typedef enum int {
        SET_SMALL,
        SET_MAX,
        SET_RESET,
        SET_DENSE,
        SET_ZERO
    } t_setting;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic [CFG_DATA_W-1:0] reg_vals [CFG_HALF:CFG_LOW];

    int mismatches;
    int outstanding;
    int items_sent   = 0;
    int src_idle_pct = 33;
    int snk_idle_pct = 88;
    int hold_reqs    = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    tpte_in_if  in_ch();
    tpte_out_if out_ch();

    tape_pulse_train_encoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tpte_waveform_check i_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic send_item(input logic f, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.data_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (items_sent < 600) begin
            src_idle_pct = 33;
            snk_idle_pct = 88;
        end else if (items_sent < 1200) begin
            src_idle_pct = 88;
            snk_idle_pct = 33;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic program_regs(input bit spare);
        for (int k = CFG_HALF; k <= CFG_LOW; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= reg_vals[k];
            @(posedge i_clk);
        end
        if (spare) begin
            // unmapped index, must be ignored
            i_cfg_idx  <= CFG_IDX_W'($urandom_range(CFG_LOW + 1, (1 << CFG_IDX_W) - 1));
            i_cfg_data <= CFG_DATA_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_level();
        return CFG_DATA_W'($urandom_range(0, 65535));
    endfunction

    task automatic pick_settings(input t_setting s);
        case (s)
            SET_MAX: begin
                reg_vals[CFG_HALF]  = 16'd63;
                reg_vals[CFG_PAUSE] = 16'd255;
                reg_vals[CFG_ZERO]  = 16'd15;
                reg_vals[CFG_ONE]   = 16'd15;
                reg_vals[CFG_HIGH]  = 16'h7FFF;
                reg_vals[CFG_LOW]   = 16'h8000;
            end
            SET_RESET: begin
                reg_vals[CFG_HALF]  = 16'(RST_HALF);
                reg_vals[CFG_PAUSE] = 16'(RST_PAUSE);
                reg_vals[CFG_ZERO]  = 16'(RST_ZERO);
                reg_vals[CFG_ONE]   = 16'(RST_ONE);
                reg_vals[CFG_HIGH]  = RST_HIGH;
                reg_vals[CFG_LOW]   = RST_LOW;
            end
            SET_DENSE: begin
                reg_vals[CFG_HALF]  = 16'd1;
                reg_vals[CFG_PAUSE] = 16'($urandom_range(0, 2));
                reg_vals[CFG_ZERO]  = 16'd15;
                reg_vals[CFG_ONE]   = 16'd15;
                reg_vals[CFG_HIGH]  = rand_level();
                reg_vals[CFG_LOW]   = rand_level();
            end
            SET_ZERO: begin
                reg_vals[CFG_HALF]  = 16'd0;
                reg_vals[CFG_PAUSE] = 16'd0;
                reg_vals[CFG_ZERO]  = 16'd0;
                reg_vals[CFG_ONE]   = 16'd0;
                reg_vals[CFG_HIGH]  = 16'h8000;
                reg_vals[CFG_LOW]   = 16'h7FFF;
            end
            default: begin
                reg_vals[CFG_HALF]  = 16'($urandom_range(0, 3));
                reg_vals[CFG_PAUSE] = 16'($urandom_range(0, 4));
                reg_vals[CFG_ZERO]  = 16'($urandom_range(0, 4));
                reg_vals[CFG_ONE]   = 16'($urandom_range(0, 6));
                reg_vals[CFG_HIGH]  = rand_level();
                reg_vals[CFG_LOW]   = ($urandom_range(7) == 0) ? reg_vals[CFG_HIGH]
                                                               : rand_level();
            end
        endcase
    endtask

    // samples needed to send byte b under the current settings
    function automatic int byte_ticks(input logic [7:0] b);
        int h;
        int p;
        int n;
        int total;
        h = (reg_vals[CFG_HALF][5:0] == 0) ? 1 : int'(reg_vals[CFG_HALF][5:0]);
        p = (reg_vals[CFG_PAUSE][7:0] == 0) ? 1 : int'(reg_vals[CFG_PAUSE][7:0]);
        total = 0;
        for (int k = 7; k >= 0; k--) begin
            n = b[k] ? int'(reg_vals[CFG_ONE][3:0]) : int'(reg_vals[CFG_ZERO][3:0]);
            if (n == 0)
                n = 1;
            total += 2 * n * h + p;
        end
        return total;
    endfunction

    task automatic run_bytes(input int budget, input bit whole);
        int         used;
        int         n;
        logic [7:0] b;
        used = 0;
        while (used < budget) begin
            b = 8'($urandom_range(255));
            send_item(FUNC_LOAD, b);
            used++;
            if (whole) begin
                n = byte_ticks(b) + $urandom_range(0, 3);
                if ($urandom_range(99) < 8)
                    n = $urandom_range(0, n);
            end else begin
                n = $urandom_range(20, 120);
            end
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(99) < 4)
                    send_item(FUNC_LOAD, 8'($urandom_range(255)));
                send_item(FUNC_TICK, 8'($urandom_range(255)));
            end
            used += n;
        end
    endtask

    initial begin
        t_setting s;
        int       phase_no;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_HALF;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= FUNC_TICK;
        in_ch.data_byte <= '0;
        pick_settings(SET_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle samples at reset levels
        send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_TICK, 8'hFF);
        wait_drained();

        // zero counts act as one; swapped extreme levels
        pick_settings(SET_ZERO);
        program_regs(1'b1);
        send_item(FUNC_LOAD, 8'hFF);
        send_item(FUNC_LOAD, 8'h00);
        repeat (24) send_item(FUNC_TICK, 8'h5A);
        send_item(FUNC_TICK, 8'hA5);

        phase_no = 0;
        while (items_sent < 1730) begin
            wait_drained();
            case (phase_no)
                0:       s = SET_MAX;
                1:       s = SET_SMALL;
                2:       s = SET_DENSE;
                3:       s = SET_RESET;
                default: s = ($urandom_range(9) < 6) ? SET_SMALL
                                                     : t_setting'($urandom_range(SET_MAX, SET_ZERO));
            endcase
            pick_settings(s);
            program_regs($urandom_range(1));
            if (phase_no == 2)
                hold_reqs++;
            if (s == SET_MAX || s == SET_RESET)
                run_bytes(150, 1'b0);
            else
                run_bytes(200, 1'b1);
            phase_no++;
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
